// ----- src/ccdb_pkg.sv -----
// Shared types and constants for the C comment and directive blanker.
// Used by the front, queue, back and top level modules.
package ccdb_pkg;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [7:0] {
		MODE_NORMAL     = 8'b0000_0001,
		MODE_STRING     = 8'b0000_0010,
		MODE_CHAR       = 8'b0000_0100,
		MODE_LINE       = 8'b0000_1000,
		MODE_BLOCK      = 8'b0001_0000,
		MODE_BLOCK_STAR = 8'b0010_0000,
		MODE_DIR        = 8'b0100_0000,
		MODE_DIR_BSL    = 8'b1000_0000
	} lex_mode_t;

	// one queue entry: one or two output bytes produced by a single item
	typedef struct packed {
		logic       two;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       last;
	} entry_t;

endpackage

// ----- src/ccdb_front.sv -----
// Front end: accepts input items, runs the lexer state machine and builds
// queue entries of one or two output bytes. Depends on ccdb_pkg.
module ccdb_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	input  logic            q_full,
	output logic            push,
	output ccdb_pkg::entry_t push_entry
);
	import ccdb_pkg::*;

	lex_mode_t  mode_q, mode_d;
	logic       held_q, held_d;
	logic       esc_q, esc_d;
	logic [1:0] n;
	logic [7:0] o0, o1;
	logic       accept;

	lex_mode_t  code_mode;
	logic [7:0] code_out;
	logic       code_hold;
	logic       code_quote;

	assign accept = in_valid && !q_full;

	always_comb begin
		code_hold  = (in_byte == CH_SLASH);
		code_quote = (in_byte == CH_DQUOTE) || (in_byte == CH_SQUOTE);
		code_out   = (in_byte == CH_HASH) ? CH_SPACE : in_byte;
		if (in_byte == CH_DQUOTE) begin
			code_mode = MODE_STRING;
		end else if (in_byte == CH_SQUOTE) begin
			code_mode = MODE_CHAR;
		end else if (in_byte == CH_HASH) begin
			code_mode = MODE_DIR;
		end else begin
			code_mode = MODE_NORMAL;
		end
	end

	always_comb begin
		n      = 2'd0;
		o0     = CH_SPACE;
		o1     = CH_SPACE;
		mode_d = mode_q;
		held_d = held_q;
		esc_d  = esc_q;
		if (held_q) begin
			held_d = 1'b0;
			n      = 2'd2;
			if (in_byte == CH_SLASH) begin
				mode_d = MODE_LINE;
			end else if (in_byte == CH_STAR) begin
				mode_d = MODE_BLOCK;
			end else begin
				o0     = CH_SLASH;
				o1     = code_out;
				mode_d = code_mode;
				if (code_quote) begin
					esc_d = 1'b0;
				end
			end
		end else begin
			case (mode_q)
				MODE_STRING, MODE_CHAR: begin
					n  = 2'd1;
					o0 = in_byte;
					if (esc_q) begin
						esc_d = 1'b0;
					end else if (in_byte == CH_BSL) begin
						esc_d = 1'b1;
					end else if ((mode_q == MODE_STRING && in_byte == CH_DQUOTE) ||
						(mode_q == MODE_CHAR && in_byte == CH_SQUOTE)) begin
						mode_d = MODE_NORMAL;
					end
				end
				MODE_LINE: begin
					n = 2'd1;
					if (in_byte == CH_NL) begin
						o0     = in_byte;
						mode_d = MODE_NORMAL;
					end
				end
				MODE_BLOCK: begin
					n = 2'd1;
					if (in_byte == CH_STAR) begin
						mode_d = MODE_BLOCK_STAR;
					end
				end
				MODE_BLOCK_STAR: begin
					n = 2'd1;
					if (in_byte == CH_SLASH) begin
						mode_d = MODE_NORMAL;
					end else if (in_byte != CH_STAR) begin
						mode_d = MODE_BLOCK;
					end
				end
				MODE_DIR: begin
					n = 2'd1;
					if (in_byte == CH_NL) begin
						o0     = in_byte;
						mode_d = MODE_NORMAL;
					end else if (in_byte == CH_BSL) begin
						mode_d = MODE_DIR_BSL;
					end
				end
				MODE_DIR_BSL: begin
					n = 2'd1;
					if (in_byte != CH_BSL) begin
						mode_d = MODE_DIR;
					end
				end
				default: begin
					if (code_hold) begin
						held_d = 1'b1;
					end else begin
						n      = 2'd1;
						o0     = code_out;
						mode_d = code_mode;
						if (code_quote) begin
							esc_d = 1'b0;
						end
					end
				end
			endcase
		end
		if (in_last) begin
			// flush a held slash, then start a fresh text
			if (held_d) begin
				n  = 2'd1;
				o0 = CH_SLASH;
			end
			held_d = 1'b0;
			mode_d = MODE_NORMAL;
			esc_d  = 1'b0;
		end
	end

	assign push             = accept && (n != 2'd0);
	assign push_entry.two   = (n == 2'd2);
	assign push_entry.byte0 = o0;
	assign push_entry.byte1 = o1;
	assign push_entry.last  = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			held_q <= 1'b0;
			esc_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			held_q <= held_d;
			esc_q  <= esc_d;
		end
	end

endmodule

// ----- src/ccdb_fifo.sv -----
// Short entry queue between the front and back ends.
// Depends on ccdb_pkg for the entry type.
module ccdb_fifo #(
	parameter int DEPTH = ccdb_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ccdb_pkg::entry_t wdata,
	input  logic             pop,
	output ccdb_pkg::entry_t rdata,
	output logic             full,
	output logic             empty
);
	import ccdb_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/ccdb_back.sv -----
// Back end: splits queue entries into single bytes and holds them in the
// output register. Depends on ccdb_pkg for the entry type.
module ccdb_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  ccdb_pkg::entry_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic             out_last
);
	import ccdb_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       phase_q;
	logic       load;
	logic       final_byte;

	assign load       = !q_empty && (!valid_q || !out_stall);
	assign final_byte = !head.two || phase_q;
	assign pop        = load && final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= !final_byte;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= phase_q ? head.byte1 : head.byte0;
			last_q <= head.last && final_byte;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

endmodule

// ----- src/c_comment_directive_blanker.sv -----
// Top level of the C comment and directive blanker.
// Depends on ccdb_pkg, ccdb_front, ccdb_fifo and ccdb_back.
//
//   port group  | handshake            | payload
//   ------------+----------------------+-------------------
//   input       | in_valid / in_stall  | in_byte, in_last
//   output      | out_valid / out_stall| out_byte, out_last
//
// One input item is taken per cycle while the entry queue has room.
// The output register gives one byte per cycle while out_stall is low, so an item
// that yields two bytes (released slash, comment opener) is sent as two bytes in turn.
// Each byte passes through the entry queue and then the output register.
// in_stall rises only when the queue is full; out_stall backs up the queue.
// Reset returns the lexer to normal code and empties the queue.
module c_comment_directive_blanker #(
	parameter int QUEUE_DEPTH = ccdb_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import ccdb_pkg::*;

	entry_t push_entry, head;
	logic   push, pop, q_full, q_empty;

	assign in_stall = q_full;

	ccdb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	ccdb_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_entry),
		.pop    (pop),
		.rdata  (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	ccdb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule
